FILE: src/bmix_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the bass redirect mixer
package bmix_pkg;

   localparam int MAX_MAINS_DEF   = 7;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = 28;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 3;

   // unity gain in Q3.28
   localparam logic signed [COEF_W-1:0] COEF_ONE =
      {{(COEF_W-COEF_FRAC-1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE,
      REG_COUNT,
      REG_B0,
      REG_B1,
      REG_B2,
      REG_A1,
      REG_A2
   } csr_reg_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   // per-frame control that rides along the pipeline
   typedef struct packed {
      logic filt_en;
      logic blk;
   } side_type;

endpackage

FILE: src/bmix_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces for the bass redirect mixer
interface bmix_req_if
   import bmix_pkg::*;
#(
   parameter int MAX_MAINS   = MAX_MAINS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                                   valid;
   logic                                   ready;
   logic signed [SAMPLE_BITS-1:0]          lfe_in;
   logic [MAX_MAINS-1:0][SAMPLE_BITS-1:0]  main;
   logic                                   block_end;

   modport source (output valid, lfe_in, main, block_end, input ready);
   modport sink   (input valid, lfe_in, main, block_end, output ready);
endinterface

interface bmix_rsp_if
   import bmix_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] lfe_out;
   logic                          clipped;
   logic                          block_end_out;

   modport source (output valid, lfe_out, clipped, block_end_out, input ready);
   modport sink   (input valid, lfe_out, clipped, block_end_out, output ready);
endinterface

FILE: src/bmix_lane.sv
`timescale 1ns / 1ps
// one main-channel lane: gates its sample by the channel count and registers it
module bmix_lane
   import bmix_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int LANE        = 0
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [CNT_W-1:0]              count,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] lane_ff
);

   logic                          active;
   logic signed [SAMPLE_BITS-1:0] lane_in;

   assign active  = int'(unsigned'(count)) > LANE;
   assign lane_in = active ? sample : '0;

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule

FILE: src/bmix_merge.sv
`timescale 1ns / 1ps
// merge stage: sums lfe with the lane samples and saturates the mix
module bmix_merge
   import bmix_pkg::*;
#(
   parameter int MAX_MAINS   = MAX_MAINS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  side_type                              in_side,
   input  logic signed [SAMPLE_BITS-1:0]         lfe,
   input  logic [MAX_MAINS-1:0][SAMPLE_BITS-1:0] lanes,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output side_type                              out_side,
   output logic signed [SAMPLE_BITS+2:0]         mix_x,
   output logic                                  mix_clip
);

   localparam int HIST_W = SAMPLE_BITS + 3;
   localparam int SUM_W  = SAMPLE_BITS + 4;
   localparam logic signed [SUM_W-1:0] HMAX =
      {{(SUM_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] HMIN = ~HMAX;

   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  sum_sat;
   logic                     over;
   logic signed [HIST_W-1:0] x_in;
   logic                     clip_in;
   logic                     valid_ff;
   side_type                 side_ff;
   logic signed [HIST_W-1:0] x_ff;
   logic                     clip_ff;
   logic                     load;

   always_comb begin
      sum = SUM_W'(lfe);
      for (int i = 0; i < MAX_MAINS; i++) begin
         sum = sum + SUM_W'($signed(lanes[i]));
      end
   end

   always_comb begin
      over    = 1'b1;
      sum_sat = sum;
      if (sum > HMAX) begin
         sum_sat = HMAX;
      end else if (sum < HMIN) begin
         sum_sat = HMIN;
      end else begin
         over = 1'b0;
      end
   end

   // bypassed frames carry the raw lfe sample forward
   assign x_in    = in_side.filt_en ? sum_sat[HIST_W-1:0] : HIST_W'(lfe);
   assign clip_in = in_side.filt_en && over;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         side_ff <= in_side;
         x_ff    <= x_in;
         clip_ff <= clip_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign mix_x     = x_ff;
   assign mix_clip  = clip_ff;

endmodule

FILE: src/bmix_biquad.sv
`timescale 1ns / 1ps
// direct-form-1 biquad: feedforward products, feedforward sum, feedback and output stage
module bmix_biquad
   import bmix_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hist_clr,
   input  coef_type                      coef,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  side_type                      mix_side,
   input  logic signed [SAMPLE_BITS+2:0] mix_x,
   input  logic                          mix_clip,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] lfe_out,
   output logic                          clipped,
   output logic                          block_end_out
);

   localparam int HIST_W = SAMPLE_BITS + 3;
   localparam int PROD_W = COEF_W + HIST_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam int YF_W   = ACC_W - COEF_FRAC;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [YF_W-1:0] HMAX =
      {{(YF_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
   localparam logic signed [YF_W-1:0] HMIN = ~HMAX;
   localparam logic signed [HIST_W-1:0] SMAX =
      {{(HIST_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [HIST_W-1:0] SMIN = ~SMAX;

   // history
   logic signed [HIST_W-1:0] xh1_ff, xh2_ff, yh1_ff;
   logic signed [PROD_W-1:0] fb2_ff;   // a2 times the output two frames back

   // product stage
   logic                     s2_valid_ff;
   side_type                 s2_side_ff;
   logic signed [HIST_W-1:0] s2_x_ff;
   logic                     s2_clip_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic                     load2;

   // feedforward sum stage
   logic                     s3_valid_ff;
   side_type                 s3_side_ff;
   logic signed [HIST_W-1:0] s3_x_ff;
   logic                     s3_clip_ff;
   logic signed [ACC_W-1:0]  sum_ff;
   logic signed [ACC_W-1:0]  sum_in;
   logic                     s3_ready;
   logic                     load3;

   // feedback and output stage
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] lfe_out_ff;
   logic                          clip_out_ff;
   logic                          blk_ff;
   logic                          rsp_en_ff;
   logic                          s4_ready;
   logic                          load4;
   logic signed [PROD_W-1:0]      fb1;
   logic signed [PROD_W-1:0]      fb2_in;
   logic signed [ACC_W-1:0]       acc;
   logic signed [YF_W-1:0]        y_full;
   logic signed [HIST_W-1:0]      y_hist;
   logic signed [HIST_W-1:0]      y_samp;
   logic                          ovf_h, ovf_s;

   assign in_ready = !s2_valid_ff || s3_ready;
   assign load2    = in_valid && in_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign load3    = s2_valid_ff && s3_ready;
   assign s4_ready = !rsp_valid_ff || rsp_ready;
   assign load4    = s3_valid_ff && s4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s2_valid_ff <= in_valid;
      end
      if (load2) begin
         s2_side_ff <= mix_side;
         s2_x_ff    <= mix_x;
         s2_clip_ff <= mix_clip;
         p0_ff      <= PROD_W'(coef.b0) * PROD_W'(mix_x);
         p1_ff      <= PROD_W'(coef.b1) * PROD_W'(xh1_ff);
         p2_ff      <= PROD_W'(coef.b2) * PROD_W'(xh2_ff);
      end
   end

   assign sum_in = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (load3) begin
         s3_side_ff <= s2_side_ff;
         s3_x_ff    <= s2_x_ff;
         s3_clip_ff <= s2_clip_ff;
         sum_ff     <= sum_in;
      end
   end

   assign fb1    = PROD_W'(coef.a1) * PROD_W'(yh1_ff);
   assign fb2_in = PROD_W'(coef.a2) * PROD_W'(yh1_ff);
   assign acc    = sum_ff - ACC_W'(fb1) - ACC_W'(fb2_ff);
   // arithmetic shift by the fraction width; rounding offset was added earlier
   assign y_full = $signed(acc[ACC_W-1:COEF_FRAC]);

   always_comb begin
      ovf_h  = 1'b1;
      y_hist = y_full[HIST_W-1:0];
      if (y_full > HMAX) begin
         y_hist = HMAX[HIST_W-1:0];
      end else if (y_full < HMIN) begin
         y_hist = HMIN[HIST_W-1:0];
      end else begin
         ovf_h = 1'b0;
      end
   end

   always_comb begin
      ovf_s  = 1'b1;
      y_samp = y_hist;
      if (y_hist > SMAX) begin
         y_samp = SMAX;
      end else if (y_hist < SMIN) begin
         y_samp = SMIN;
      end else begin
         ovf_s = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (load4) begin
         blk_ff    <= s3_side_ff.blk;
         rsp_en_ff <= s3_side_ff.filt_en;
         if (s3_side_ff.filt_en) begin
            lfe_out_ff  <= y_samp[SAMPLE_BITS-1:0];
            clip_out_ff <= s3_clip_ff || ovf_h || ovf_s;
         end else begin
            lfe_out_ff  <= s3_x_ff[SAMPLE_BITS-1:0];
            clip_out_ff <= 1'b0;
         end
      end
   end

   // history moves only on filtered frames
   always_ff @(posedge clock) begin
      if (reset || hist_clr) begin
         xh1_ff <= '0;
         xh2_ff <= '0;
         yh1_ff <= '0;
         fb2_ff <= '0;
      end else begin
         if (load2 && mix_side.filt_en) begin
            xh2_ff <= xh1_ff;
            xh1_ff <= mix_x;
         end
         if (load4 && s3_side_ff.filt_en) begin
            yh1_ff <= y_hist;
            fb2_ff <= fb2_in;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign lfe_out       = lfe_out_ff;
   assign clipped       = clip_out_ff;
   assign block_end_out = blk_ff;

   a_bypass_keeps_hist: assert property (@(posedge clock) disable iff (reset)
      (load4 && !s3_side_ff.filt_en && !hist_clr) |=> ($stable(yh1_ff) && $stable(fb2_ff)))
      else $error("bypassed frame changed output history");

   a_clear_hist: assert property (@(posedge clock) disable iff (reset)
      hist_clr |=> (xh1_ff == '0 && xh2_ff == '0 && yh1_ff == '0 && fb2_ff == '0))
      else $error("history not cleared after register write");

   a_bypass_no_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_en_ff) |-> !clip_out_ff)
      else $error("bypassed frame flagged as clipped");

   a_sum_held: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s4_ready) |=> (s3_valid_ff && $stable(sum_ff)))
      else $error("feedforward sum lost while output stalled");

endmodule

FILE: src/bass_redirect_lowpass_mixer.sv
`timescale 1ns / 1ps
// Bass redirect mixer: adds the first main_count main channels into the LFE
// sample, then runs the sum through a direct-form-1 biquad lowpass with five
// Q3.28 coefficients (y = round(b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2), rounded
// half up, saturated). With redirect_enable low the LFE sample passes through
// untouched and the filter history is left alone. One frame is accepted every
// cycle while the response channel is not stalled; a frame passes through the lane
// register, mix merge, feedforward products, feedforward sum, and feedback and
// output register before its result appears. The sustained rate is set by the
// feedback stage, which does the a1 multiply-accumulate on the previous output combinationally.
// Any write to a defined register clears the history at once; writes are
// expected only while no frame is in flight.
module bass_redirect_lowpass_mixer
   import bmix_pkg::*;
#(
   parameter int MAX_MAINS   = MAX_MAINS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   bmix_req_if.sink             req_ch,
   bmix_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   // configuration
   logic             enable_ff;
   logic [CNT_W-1:0] count_ff;
   coef_type         coef_ff;
   logic             hist_clr;

   // lane stage
   logic                                  s0_valid_ff;
   side_type                              s0_side_ff;
   logic signed [SAMPLE_BITS-1:0]         lfe0_ff;
   logic [MAX_MAINS-1:0][SAMPLE_BITS-1:0] lane_q;
   logic                                  load0;
   side_type                              side0_in;

   // merge to filter
   logic                          merge_ready;
   logic                          mix_valid;
   logic                          mix_ready;
   side_type                      mix_side;
   logic signed [SAMPLE_BITS+2:0] mix_x;
   logic                          mix_clip;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
         coef_ff   <= '{b0: COEF_ONE, default: '0};
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_ENABLE: enable_ff  <= csr_wdata[0];
            REG_COUNT:  count_ff   <= csr_wdata[CNT_W-1:0];
            REG_B0:     coef_ff.b0 <= csr_wdata;
            REG_B1:     coef_ff.b1 <= csr_wdata;
            REG_B2:     coef_ff.b2 <= csr_wdata;
            REG_A1:     coef_ff.a1 <= csr_wdata;
            REG_A2:     coef_ff.a2 <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign hist_clr = csr_we && (csr_index inside {[REG_ENABLE:REG_A2]});

   assign req_ch.ready = !s0_valid_ff || merge_ready;
   assign load0        = req_ch.valid && req_ch.ready;
   assign side0_in     = '{filt_en: enable_ff, blk: req_ch.block_end};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s0_valid_ff <= req_ch.valid;
      end
      if (load0) begin
         s0_side_ff <= side0_in;
         lfe0_ff    <= req_ch.lfe_in;
      end
   end

   for (genvar g = 0; g < MAX_MAINS; g++) begin : g_lane
      bmix_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .LANE        (g)
      ) u_lane (
         .clock   (clock),
         .load    (load0),
         .count   (count_ff),
         .sample  ($signed(req_ch.main[g])),
         .lane_ff (lane_q[g])
      );
   end

   bmix_merge #(
      .MAX_MAINS   (MAX_MAINS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (merge_ready),
      .in_side   (s0_side_ff),
      .lfe       (lfe0_ff),
      .lanes     (lane_q),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_side  (mix_side),
      .mix_x     (mix_x),
      .mix_clip  (mix_clip)
   );

   bmix_biquad #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_biquad (
      .clock         (clock),
      .reset         (reset),
      .hist_clr      (hist_clr),
      .coef          (coef_ff),
      .in_valid      (mix_valid),
      .in_ready      (mix_ready),
      .mix_side      (mix_side),
      .mix_x         (mix_x),
      .mix_clip      (mix_clip),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .lfe_out       (rsp_ch.lfe_out),
      .clipped       (rsp_ch.clipped),
      .block_end_out (rsp_ch.block_end_out)
   );

endmodule
